[rtl/lzssbd_pkg.sv]
// ============================================================================
// LZSS bitstream decompressor - shared types and constants
// Token phases, emission kinds, sequencer states and the token descriptor
// passed from the bit parser to the copy sequencer.
// ============================================================================
`default_nettype none

package lzssbd_pkg;

    // Literal width in bits
    localparam int unsigned LIT_BITS  = 8;
    // Width of the output length register and the produced byte counter
    localparam int unsigned LEN_W     = 24;
    // Widest ring offset supported by the token descriptor
    localparam int unsigned OFF_MAX_W = 12;
    // Widest copy run supported by the token descriptor (up to 63 bytes)
    localparam int unsigned RUN_MAX_W = 6;

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_LITERAL,
        PH_MATCH
    } phase_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_LITERAL,
        EMIT_MATCH
    } emit_kind_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_LITERAL,
        SEQ_FETCH,
        SEQ_COPY
    } seq_state_t;

    typedef struct packed {
        emit_kind_t              kind;
        logic [LIT_BITS-1:0]     literal;
        logic [OFF_MAX_W-1:0]    offset;
        logic [RUN_MAX_W-1:0]    run;
    } token_t;

endpackage

`default_nettype wire

[rtl/lzss_bitstream_decompress_core.sv]
// ============================================================================
// LZSS bitstream decompressor - top level
// Parses packed bytes into literal and match tokens and replays matches from
// a 2^OFFSET_BITS byte history ring, one decoded byte per cycle while the output is not stalled.
// ============================================================================
// Each accepted packed byte is parsed in its accept cycle. A byte that
// completes no token needs no further work; a byte that completes a literal
// then passes through the literal state; a byte that completes a match of n
// bytes passes through one ring fetch, then copies one byte per cycle through
// the ring's single read port while the output is not stalled, with n at most
// 2^LENGTH_BITS + 1. The ring is not swept at stream start: a fill count marks
// which entries hold stream data and the others read as zero, so a new stream
// starts without a clearing pass. Write output_length only while the block
// is idle; the configuration port is ready only when no byte is in work and
// none is offered.
`default_nettype none

module lzss_bitstream_decompress_core #(
    parameter int unsigned OFFSET_BITS = 8,
    parameter int unsigned LENGTH_BITS = 4
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [lzssbd_pkg::LIT_BITS-1:0] packed_byte,
    input  wire logic                            stream_start,

    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [lzssbd_pkg::LIT_BITS-1:0] plain_byte,
    output logic                                 run_last,
    output logic                                 stream_done,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [lzssbd_pkg::LEN_W-1:0]    cfg_data
);

    localparam int unsigned RUN_W = LENGTH_BITS + 1;

    lzssbd_pkg::seq_state_t          state_reg;
    lzssbd_pkg::seq_state_t          state_next;
    lzssbd_pkg::token_t              token;

    logic [OFFSET_BITS-1:0]          src_reg;
    logic [RUN_W-1:0]                left_reg;
    logic [lzssbd_pkg::LIT_BITS-1:0] lit_reg;
    logic [lzssbd_pkg::LEN_W-1:0]    produced_reg;
    logic [lzssbd_pkg::LEN_W-1:0]    output_length_reg;

    logic                            out_valid_reg;
    logic [lzssbd_pkg::LIT_BITS-1:0] plain_byte_reg;
    logic                            run_last_reg;
    logic                            stream_done_reg;

    logic                            in_accept;
    logic                            out_free;
    logic                            out_load;
    logic                            rd_en;
    logic                            emit_last;
    logic [lzssbd_pkg::LIT_BITS-1:0] emit_data;
    logic [lzssbd_pkg::LIT_BITS-1:0] ring_rd_data;

    assign in_stall  = (state_reg != lzssbd_pkg::SEQ_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = (state_reg == lzssbd_pkg::SEQ_IDLE) && !in_valid;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign plain_byte  = plain_byte_reg;
    assign run_last    = run_last_reg;
    assign stream_done = stream_done_reg;

    lzssbd_token_parser #(
        .OFFSET_BITS (OFFSET_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .packed_byte   (packed_byte),
        .stream_start  (stream_start),
        .produced      (produced_reg),
        .output_length (output_length_reg),
        .token         (token)
    );

    lzssbd_ring_ram #(
        .OFFSET_BITS (OFFSET_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (in_accept && stream_start),
        .wr_en   (out_load),
        .wr_data (emit_data),
        .rd_en   (rd_en),
        .rd_addr (src_reg),
        .rd_data (ring_rd_data)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lzssbd_pkg::SEQ_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (token.kind)
                        lzssbd_pkg::EMIT_LITERAL: state_next = lzssbd_pkg::SEQ_LITERAL;
                        lzssbd_pkg::EMIT_MATCH:   state_next = lzssbd_pkg::SEQ_FETCH;
                        default:                  state_next = lzssbd_pkg::SEQ_IDLE;
                    endcase
                end
            end
            lzssbd_pkg::SEQ_LITERAL:
            begin
                if (out_free)
                begin
                    state_next = lzssbd_pkg::SEQ_IDLE;
                end
            end
            lzssbd_pkg::SEQ_FETCH:
            begin
                state_next = lzssbd_pkg::SEQ_COPY;
            end
            default:
            begin
                if (out_free && (left_reg == RUN_W'(1)))
                begin
                    state_next = lzssbd_pkg::SEQ_IDLE;
                end
            end
        endcase
    end

    // Datapath control
    always_comb
    begin
        rd_en     = 1'b0;
        out_load  = 1'b0;
        emit_data = lit_reg;
        emit_last = 1'b1;
        unique case (state_reg)
            lzssbd_pkg::SEQ_LITERAL:
            begin
                out_load = out_free;
            end
            lzssbd_pkg::SEQ_FETCH:
            begin
                rd_en = 1'b1;
            end
            lzssbd_pkg::SEQ_COPY:
            begin
                out_load  = out_free;
                emit_data = ring_rd_data;
                emit_last = (left_reg == RUN_W'(1));
                // hold the fetched byte while the output is stalled
                rd_en     = out_free && !emit_last;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= lzssbd_pkg::SEQ_IDLE;
            src_reg           <= '0;
            left_reg          <= '0;
            produced_reg      <= '0;
            output_length_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                output_length_reg <= cfg_data;
            end

            if (in_accept)
            begin
                src_reg  <= OFFSET_BITS'(token.offset);
                left_reg <= RUN_W'(token.run);
            end
            else
            begin
                if (rd_en)
                begin
                    src_reg <= src_reg + OFFSET_BITS'(1);
                end
                if (out_load && (state_reg == lzssbd_pkg::SEQ_COPY))
                begin
                    left_reg <= left_reg - RUN_W'(1);
                end
            end

            if (in_accept && stream_start)
            begin
                produced_reg <= '0;
            end
            else if (out_load)
            begin
                produced_reg <= produced_reg + lzssbd_pkg::LEN_W'(1);
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            lit_reg <= token.literal;
        end
        if (out_load)
        begin
            plain_byte_reg  <= emit_data;
            run_last_reg    <= emit_last;
            stream_done_reg <= ((produced_reg + lzssbd_pkg::LEN_W'(1)) == output_length_reg);
        end
    end

    a_copy_run_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lzssbd_pkg::SEQ_COPY) |-> (left_reg != '0))
        else $error("copy state entered with no bytes left to copy");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (produced_reg < output_length_reg))
        else $error("byte emitted beyond the configured output length");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && stream_done_reg) |-> run_last_reg)
        else $error("stream completed on a byte that is not the last of its run");

    a_job_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && emit_last) |=> (state_reg == lzssbd_pkg::SEQ_IDLE))
        else $error("sequencer busy after the last byte of a run");

endmodule

`default_nettype wire

[rtl/lzssbd_ring_ram.sv]
// ============================================================================
// LZSS history ring
// Synchronous single-write, single-read ring memory with an appending write
// pointer, a fill count standing in for the clear, and write-to-read forwarding.
// ============================================================================
`default_nettype none

module lzssbd_ring_ram #(
    parameter int unsigned OFFSET_BITS = 8,
    parameter int unsigned LENGTH_BITS = 4
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         clear,
    input  wire logic                         wr_en,
    input  wire logic [lzssbd_pkg::LIT_BITS-1:0] wr_data,
    input  wire logic                         rd_en,
    input  wire logic [OFFSET_BITS-1:0]       rd_addr,
    output logic      [lzssbd_pkg::LIT_BITS-1:0] rd_data
);

    localparam int unsigned RING_SIZE = 2 ** OFFSET_BITS;
    localparam int unsigned LOOKAHEAD = (2 ** LENGTH_BITS) + 1;
    localparam int unsigned START_POS = ((4 * RING_SIZE) - LOOKAHEAD) % RING_SIZE;

    logic [lzssbd_pkg::LIT_BITS-1:0] mem [RING_SIZE];

    logic [OFFSET_BITS-1:0]          wpos_reg;
    logic [OFFSET_BITS:0]            fill_reg;
    logic                            fwd_hit_reg;
    logic                            live_reg;
    logic [lzssbd_pkg::LIT_BITS-1:0] fwd_data_reg;
    logic [lzssbd_pkg::LIT_BITS-1:0] q_reg;
    logic [OFFSET_BITS-1:0]          rd_rel;
    logic                            rd_live;

    // Entries are written in order from the start position, so an entry holds
    // stream data exactly when its distance from the start is below the fill.
    assign rd_rel  = rd_addr - OFFSET_BITS'(START_POS);
    assign rd_live = ({1'b0, rd_rel} < fill_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg    <= OFFSET_BITS'(START_POS);
            fill_reg    <= '0;
            fwd_hit_reg <= 1'b0;
            live_reg    <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                wpos_reg <= OFFSET_BITS'(START_POS);
                fill_reg <= '0;
            end
            else if (wr_en)
            begin
                wpos_reg <= wpos_reg + OFFSET_BITS'(1);
                if (fill_reg != (OFFSET_BITS+1)'(RING_SIZE))
                begin
                    fill_reg <= fill_reg + (OFFSET_BITS+1)'(1);
                end
            end
            if (rd_en)
            begin
                // read and write of the same entry in one cycle: take the new byte
                fwd_hit_reg <= wr_en && (rd_addr == wpos_reg);
                live_reg    <= rd_live;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wpos_reg] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg        <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_comb
    begin
        if (fwd_hit_reg)
        begin
            rd_data = fwd_data_reg;
        end
        else if (live_reg)
        begin
            rd_data = q_reg;
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule

`default_nettype wire

[rtl/lzssbd_token_parser.sv]
// ============================================================================
// LZSS token parser
// Walks the eight bits of an accepted byte MSB first, keeps the partial token
// between bytes and reports the literal or match that the byte completes.
// ============================================================================
`default_nettype none

module lzssbd_token_parser #(
    parameter int unsigned OFFSET_BITS = 8,
    parameter int unsigned LENGTH_BITS = 4
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            accept,
    input  wire logic [lzssbd_pkg::LIT_BITS-1:0] packed_byte,
    input  wire logic                            stream_start,
    input  wire logic [lzssbd_pkg::LEN_W-1:0]    produced,
    input  wire logic [lzssbd_pkg::LEN_W-1:0]    output_length,
    output lzssbd_pkg::token_t                   token
);

    localparam int unsigned MATCH_BITS = OFFSET_BITS + LENGTH_BITS;
    localparam int unsigned FIELD_W    = (MATCH_BITS > lzssbd_pkg::LIT_BITS) ?
                                         MATCH_BITS : lzssbd_pkg::LIT_BITS;
    localparam int unsigned CNT_W      = $clog2(FIELD_W + 1);
    localparam int unsigned RUN_W      = LENGTH_BITS + 1;
    localparam int unsigned RUN_CAP    = (2 ** RUN_W) - 1;

    lzssbd_pkg::phase_t  phase_reg;
    lzssbd_pkg::phase_t  phase_next;
    logic [FIELD_W-1:0]  field_reg;
    logic [FIELD_W-1:0]  field_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    always_comb
    begin : parse
        lzssbd_pkg::phase_t          ph;
        logic [FIELD_W-1:0]          fb;
        logic [CNT_W-1:0]            fc;
        logic [lzssbd_pkg::LEN_W-1:0] prod_eff;
        logic [lzssbd_pkg::LEN_W-1:0] remaining;
        logic [RUN_W-1:0]            rem_clip;
        logic [RUN_W-1:0]            run_len;
        logic                        stop;
        logic                        b;

        if (stream_start)
        begin
            ph       = lzssbd_pkg::PH_FLAG;
            fb       = '0;
            fc       = '0;
            prod_eff = '0;
        end
        else
        begin
            ph       = phase_reg;
            fb       = field_reg;
            fc       = count_reg;
            prod_eff = produced;
        end

        stop      = (prod_eff >= output_length);
        remaining = output_length - prod_eff;
        rem_clip  = (remaining > lzssbd_pkg::LEN_W'(RUN_CAP)) ?
                    RUN_W'(RUN_CAP) : remaining[RUN_W-1:0];
        run_len   = '0;
        b         = 1'b0;

        token         = '0;
        token.kind    = lzssbd_pkg::EMIT_NONE;

        for (int i = lzssbd_pkg::LIT_BITS - 1; i >= 0; i--)
        begin
            if (!stop)
            begin
                b = packed_byte[i];
                unique case (ph)
                    lzssbd_pkg::PH_LITERAL:
                    begin
                        fb = {fb[FIELD_W-2:0], b};
                        fc = fc + CNT_W'(1);
                        if (fc == CNT_W'(lzssbd_pkg::LIT_BITS))
                        begin
                            token.kind    = lzssbd_pkg::EMIT_LITERAL;
                            token.literal = fb[lzssbd_pkg::LIT_BITS-1:0];
                            ph            = lzssbd_pkg::PH_FLAG;
                            // drop the rest of the byte once the length is met
                            stop          = (rem_clip <= RUN_W'(1));
                        end
                    end
                    lzssbd_pkg::PH_MATCH:
                    begin
                        fb = {fb[FIELD_W-2:0], b};
                        fc = fc + CNT_W'(1);
                        if (fc == CNT_W'(MATCH_BITS))
                        begin
                            run_len      = RUN_W'(fb[LENGTH_BITS-1:0]) + RUN_W'(2);
                            token.kind   = lzssbd_pkg::EMIT_MATCH;
                            token.offset = lzssbd_pkg::OFF_MAX_W'(
                                               fb[MATCH_BITS-1:LENGTH_BITS]);
                            token.run    = lzssbd_pkg::RUN_MAX_W'(
                                               (run_len < rem_clip) ? run_len : rem_clip);
                            ph           = lzssbd_pkg::PH_FLAG;
                            stop         = (rem_clip <= run_len);
                        end
                    end
                    default:
                    begin
                        ph = b ? lzssbd_pkg::PH_LITERAL : lzssbd_pkg::PH_MATCH;
                        fb = '0;
                        fc = '0;
                    end
                endcase
            end
        end

        phase_next = ph;
        field_next = fb;
        count_next = fc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= lzssbd_pkg::PH_FLAG;
            field_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            field_reg <= field_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire
